FILE: sv/qpt_pkg.sv
// ----------------------------------------------------------------------------
// qpt_pkg: shared types and constants of the qubit placement table
// Transaction payload structs, action codes and slot state codes.
// ----------------------------------------------------------------------------
package qpt_pkg;

  // Hard ceiling on the number of slots and qubits that the table can index.
  localparam int IDX_LIMIT = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;

  // Action codes.
  localparam logic [3:0] ACT_ADD     = 4'd0;
  localparam logic [3:0] ACT_REMOVE  = 4'd1;
  localparam logic [3:0] ACT_SWAP    = 4'd2;
  localparam logic [3:0] ACT_TRIVIAL = 4'd3;
  localparam logic [3:0] ACT_PAIR    = 4'd4;
  localparam logic [3:0] ACT_NEXT    = 4'd5;
  localparam logic [3:0] ACT_CLEAR   = 4'd6;
  localparam logic [3:0] ACT_REM_ALL = 4'd7;
  localparam logic [3:0] ACT_CHECK   = 4'd8;

  // Program slot states.
  localparam logic [1:0] ST_EXCLUDED = 2'd0;
  localparam logic [1:0] ST_VIRTUAL  = 2'd1;
  localparam logic [1:0] ST_MAPPED   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_PROG = 1'b0;
  localparam logic CFG_PHYS = 1'b1;

  typedef struct packed {
    logic [3:0]       action;
    logic [IDX_W-1:0] prog_id;
    logic [IDX_W-1:0] phys_a;
    logic [IDX_W-1:0] phys_b;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic [1:0]       prog_state;
    logic [IDX_W-1:0] prog_phys;
    logic             phys_busy;
    logic [IDX_W-1:0] phys_owner;
  } out_t;

endpackage

FILE: sv/qubit_placement_table.sv
// ----------------------------------------------------------------------------
// qubit_placement_table: two-way placement table of program slots and qubits
// One transaction at a time; the next one is taken once the block is back in
// idle after issuing the result, and a stalled result holds the block.
// The walking actions are set by one sequencer that visits one table entry per
// step through target and owner RAMs with one read and one write port each.
// Synchronous reset: all slots excluded, all qubits free, config registers zero.
// ----------------------------------------------------------------------------
module qubit_placement_table #(
  parameter int PROG_SLOTS = 64,
  parameter int PHYS_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  qpt_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qpt_pkg::out_t      out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [qpt_pkg::CNT_W-1:0] cfg_data
);

  localparam int W = qpt_pkg::IDX_W;
  localparam int C = qpt_pkg::CNT_W;
  localparam int N = qpt_pkg::IDX_LIMIT;
  localparam logic [C-1:0] PCAP = C'((PROG_SLOTS < N) ? PROG_SLOTS : N);
  localparam logic [C-1:0] QCAP = C'((PHYS_SLOTS < N) ? PHYS_SLOTS : N);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_REM  = 5'd2;
  localparam logic [4:0] S_SW1  = 5'd3;
  localparam logic [4:0] S_SW2  = 5'd4;
  localparam logic [4:0] S_SW3  = 5'd5;
  localparam logic [4:0] S_TMC  = 5'd6;
  localparam logic [4:0] S_TMM  = 5'd7;
  localparam logic [4:0] S_ANS  = 5'd8;
  localparam logic [4:0] S_CKA  = 5'd9;
  localparam logic [4:0] S_CKA2 = 5'd10;
  localparam logic [4:0] S_CKA3 = 5'd11;
  localparam logic [4:0] S_CKB  = 5'd12;
  localparam logic [4:0] S_CKB2 = 5'd13;
  localparam logic [4:0] S_CKB3 = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  logic [4:0]   state, state_next;
  qpt_pkg::in_t item, item_next;
  logic [C-1:0] prog_cfg, phys_cfg;
  logic [1:0]   slot_st [N], slot_st_next [N];
  logic [N-1:0] busy, busy_next;
  logic [C-1:0] idx, idx_next, jdx, jdx_next;
  logic [C-1:0] nv, nv_next, nf, nf_next;
  logic [W-1:0] oa, oa_next, ob, ob_next;
  logic         ok, ok_next;
  qpt_pkg::out_t out_reg, out_reg_next;
  logic         out_valid_next;

  // Target and owner memories with registered reads.
  logic [W-1:0] tgt_mem [N];
  logic [W-1:0] own_mem [N];
  logic [W-1:0] tgt_rd, own_rd, tgt_ra, own_ra, tgt_wa, own_wa, tgt_wd, own_wd;
  logic         tgt_we, own_we;

  logic [C-1:0] p_eff, q_eff;
  logic [1:0]   st_look;
  logic         busy_look;

  // Effective counts are the smallest of register, parameter and ceiling.
  always_comb begin
    p_eff = (prog_cfg < PCAP) ? prog_cfg : PCAP;
    q_eff = (phys_cfg < QCAP) ? phys_cfg : QCAP;
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_wa] <= tgt_wd;
    end
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
    tgt_rd <= tgt_mem[tgt_ra];
    own_rd <= own_mem[own_ra];
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_data  = out_reg;

  // Lookup of the result fields after the action.
  always_comb begin
    st_look   = ({1'b0, item.prog_id} < p_eff) ? slot_st[item.prog_id]
                                               : qpt_pkg::ST_EXCLUDED;
    busy_look = ({1'b0, item.phys_a} < q_eff) ? busy[item.phys_a] : 1'b0;
  end

  // Sequencer: one table entry is visited per step.
  always_comb begin
    state_next     = state;
    item_next      = item;
    slot_st_next   = slot_st;
    busy_next      = busy;
    idx_next       = idx;
    jdx_next       = jdx;
    nv_next        = nv;
    nf_next        = nf;
    oa_next        = oa;
    ob_next        = ob;
    ok_next        = ok;
    out_reg_next   = out_reg;
    out_valid_next = out_valid && out_stall;
    tgt_ra = item.prog_id;
    own_ra = item.phys_a;
    tgt_we = 1'b0;
    own_we = 1'b0;
    tgt_wa = '0;
    own_wa = '0;
    tgt_wd = '0;
    own_wd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          item_next  = in_data;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        ok_next    = 1'b0;
        idx_next   = '0;
        jdx_next   = '0;
        nv_next    = '0;
        nf_next    = '0;
        state_next = S_FIN;
        case (item.action)
          qpt_pkg::ACT_ADD: begin
            if ({1'b0, item.prog_id} < p_eff &&
                slot_st[item.prog_id] == qpt_pkg::ST_EXCLUDED) begin
              slot_st_next[item.prog_id] = qpt_pkg::ST_VIRTUAL;
              ok_next = 1'b1;
            end
          end
          qpt_pkg::ACT_REMOVE: begin
            if ({1'b0, item.prog_id} < p_eff) begin
              ok_next = 1'b1;
              if (slot_st[item.prog_id] == qpt_pkg::ST_MAPPED) begin
                state_next = S_REM;
              end else begin
                slot_st_next[item.prog_id] = qpt_pkg::ST_EXCLUDED;
              end
            end
          end
          qpt_pkg::ACT_SWAP: begin
            if ({1'b0, item.phys_a} < q_eff && {1'b0, item.phys_b} < q_eff &&
                item.phys_a != item.phys_b) begin
              ok_next    = 1'b1;
              state_next = S_SW1;
            end
          end
          qpt_pkg::ACT_TRIVIAL: begin
            state_next = S_TMC;
          end
          qpt_pkg::ACT_PAIR: begin
            if ({1'b0, item.prog_id} < p_eff && {1'b0, item.phys_a} < q_eff &&
                p_eff <= q_eff) begin
              ok_next = 1'b1;
              if (slot_st[item.prog_id] == qpt_pkg::ST_VIRTUAL) begin
                slot_st_next[item.prog_id] = qpt_pkg::ST_MAPPED;
                busy_next[item.phys_a]     = 1'b1;
                tgt_we = 1'b1;
                tgt_wa = item.prog_id;
                tgt_wd = item.phys_a;
                own_we = 1'b1;
                own_wa = item.phys_a;
                own_wd = item.prog_id;
              end
            end
          end
          qpt_pkg::ACT_NEXT: begin
            if ({1'b0, item.phys_a} < q_eff) begin
              ok_next = 1'b1;
              if (!busy[item.phys_a]) begin
                state_next = S_ANS;
              end
            end
          end
          qpt_pkg::ACT_CLEAR: begin
            for (int i = 0; i < N; i++) begin
              if (C'(i) < p_eff) begin
                slot_st_next[i] = qpt_pkg::ST_VIRTUAL;
              end
            end
            busy_next = '0;
            ok_next   = 1'b1;
          end
          qpt_pkg::ACT_REM_ALL: begin
            for (int i = 0; i < N; i++) begin
              slot_st_next[i] = qpt_pkg::ST_EXCLUDED;
            end
            busy_next = '0;
            ok_next   = 1'b1;
          end
          qpt_pkg::ACT_CHECK: begin
            ok_next    = 1'b1;
            state_next = S_CKA;
          end
          default: begin
            ok_next = 1'b0;
          end
        endcase
      end
      // Removal of a mapped slot frees its qubit.
      S_REM: begin
        busy_next[tgt_rd]          = 1'b0;
        slot_st_next[item.prog_id] = qpt_pkg::ST_EXCLUDED;
        state_next                 = S_FIN;
      end
      // Swap: fetch both owners, then move them across in two write steps.
      S_SW1: begin
        oa_next    = own_rd;
        own_ra     = item.phys_b;
        state_next = S_SW2;
      end
      S_SW2: begin
        ob_next = own_rd;
        if (busy[item.phys_a]) begin
          tgt_we = 1'b1;
          tgt_wa = oa;
          tgt_wd = item.phys_b;
        end
        own_we     = 1'b1;
        own_wa     = item.phys_a;
        own_wd     = own_rd;
        state_next = S_SW3;
      end
      S_SW3: begin
        if (busy[item.phys_b]) begin
          tgt_we = 1'b1;
          tgt_wa = ob;
          tgt_wd = item.phys_a;
        end
        own_we                 = 1'b1;
        own_wa                 = item.phys_b;
        own_wd                 = oa;
        busy_next[item.phys_a] = busy[item.phys_b];
        busy_next[item.phys_b] = busy[item.phys_a];
        state_next             = S_FIN;
      end
      // Trivial mapping: count virtual slots and free qubits.
      S_TMC: begin
        if (idx < p_eff && slot_st[idx[W-1:0]] == qpt_pkg::ST_VIRTUAL) begin
          nv_next = nv + C'(1);
        end
        if (idx < q_eff && !busy[idx[W-1:0]]) begin
          nf_next = nf + C'(1);
        end
        idx_next = idx + C'(1);
        if (idx == C'(N - 1)) begin
          idx_next = '0;
          if (nf_next >= nv_next) begin
            ok_next    = 1'b1;
            state_next = S_TMM;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      // Then pair virtual slots with free qubits in ascending order.
      S_TMM: begin
        if (idx >= p_eff) begin
          state_next = S_FIN;
        end else if (slot_st[idx[W-1:0]] != qpt_pkg::ST_VIRTUAL) begin
          idx_next = idx + C'(1);
        end else if (jdx >= q_eff) begin
          state_next = S_FIN;
        end else if (busy[jdx[W-1:0]]) begin
          jdx_next = jdx + C'(1);
        end else begin
          slot_st_next[idx[W-1:0]] = qpt_pkg::ST_MAPPED;
          busy_next[jdx[W-1:0]]    = 1'b1;
          tgt_we   = 1'b1;
          tgt_wa   = idx[W-1:0];
          tgt_wd   = jdx[W-1:0];
          own_we   = 1'b1;
          own_wa   = jdx[W-1:0];
          own_wd   = idx[W-1:0];
          idx_next = idx + C'(1);
        end
      end
      // Assign next: the lowest virtual slot takes the given qubit.
      S_ANS: begin
        if (idx >= p_eff) begin
          state_next = S_FIN;
        end else if (slot_st[idx[W-1:0]] == qpt_pkg::ST_VIRTUAL) begin
          slot_st_next[idx[W-1:0]] = qpt_pkg::ST_MAPPED;
          busy_next[item.phys_a]   = 1'b1;
          tgt_we     = 1'b1;
          tgt_wa     = idx[W-1:0];
          tgt_wd     = item.phys_a;
          own_we     = 1'b1;
          own_wa     = item.phys_a;
          own_wd     = idx[W-1:0];
          state_next = S_FIN;
        end else begin
          idx_next = idx + C'(1);
        end
      end
      // Check, first pass: every mapped slot is owned back by its qubit.
      S_CKA: begin
        tgt_ra = idx[W-1:0];
        if (idx >= p_eff) begin
          idx_next   = '0;
          state_next = S_CKB;
        end else if (slot_st[idx[W-1:0]] == qpt_pkg::ST_MAPPED) begin
          state_next = S_CKA2;
        end else begin
          idx_next = idx + C'(1);
        end
      end
      S_CKA2: begin
        own_ra = tgt_rd;
        if ({1'b0, tgt_rd} >= q_eff || !busy[tgt_rd]) begin
          ok_next    = 1'b0;
          state_next = S_FIN;
        end else begin
          state_next = S_CKA3;
        end
      end
      S_CKA3: begin
        if (own_rd != idx[W-1:0]) begin
          ok_next    = 1'b0;
          state_next = S_FIN;
        end else begin
          idx_next   = idx + C'(1);
          state_next = S_CKA;
        end
      end
      // Second pass: every busy qubit points at a slot mapped back to it.
      S_CKB: begin
        own_ra = idx[W-1:0];
        if (idx >= q_eff) begin
          state_next = S_FIN;
        end else if (busy[idx[W-1:0]]) begin
          state_next = S_CKB2;
        end else begin
          idx_next = idx + C'(1);
        end
      end
      S_CKB2: begin
        tgt_ra = own_rd;
        if ({1'b0, own_rd} >= p_eff || slot_st[own_rd] != qpt_pkg::ST_MAPPED) begin
          ok_next    = 1'b0;
          state_next = S_FIN;
        end else begin
          state_next = S_CKB3;
        end
      end
      S_CKB3: begin
        if (tgt_rd != idx[W-1:0]) begin
          ok_next    = 1'b0;
          state_next = S_FIN;
        end else begin
          idx_next   = idx + C'(1);
          state_next = S_CKB;
        end
      end
      // Lookup reads are issued here and land before the result is built.
      S_FIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_reg_next.ok         = ok;
          out_reg_next.prog_state = st_look;
          out_reg_next.prog_phys  = (st_look == qpt_pkg::ST_MAPPED) ? tgt_rd : '0;
          out_reg_next.phys_busy  = busy_look;
          out_reg_next.phys_owner = busy_look ? own_rd : '0;
          out_valid_next          = 1'b1;
          state_next              = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control, table state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      busy      <= '0;
      prog_cfg  <= '0;
      phys_cfg  <= '0;
      for (int i = 0; i < N; i++) begin
        slot_st[i] <= qpt_pkg::ST_EXCLUDED;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      busy      <= busy_next;
      slot_st   <= slot_st_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == qpt_pkg::CFG_PROG) begin
          prog_cfg <= cfg_data;
        end else begin
          phys_cfg <= cfg_data;
        end
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    item    <= item_next;
    idx     <= idx_next;
    jdx     <= jdx_next;
    nv      <= nv_next;
    nf      <= nf_next;
    oa      <= oa_next;
    ob      <= ob_next;
    ok      <= ok_next;
    out_reg <= out_reg_next;
  end

endmodule
